>>> rtl/mbrc_pkg.sv
// Types and constants shared by the Modbus meter response checker.
// No dependencies; all other rtl files import this package.
`default_nettype none

package mbrc_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_LENGTH   = 3'd1;
  localparam logic [2:0] STAT_ADDRESS  = 3'd2;
  localparam logic [2:0] STAT_FUNCTION = 3'd3;
  localparam logic [2:0] STAT_CRC      = 3'd4;

  // Frame layout
  localparam int          PAYLOAD_BYTES = 20;
  localparam int          PAYLOAD_AW    = $clog2(PAYLOAD_BYTES);
  localparam logic [4:0]  IDX_ADDRESS   = 5'd0;
  localparam logic [4:0]  IDX_FUNCTION  = 5'd1;
  localparam logic [4:0]  IDX_COUNT     = 5'd2;
  localparam logic [4:0]  IDX_PAYLOAD   = 5'd3;
  localparam logic [4:0]  IDX_CRC_LOW   = 5'd23;
  localparam logic [4:0]  IDX_CRC_HIGH  = 5'd24;

  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_READ_IN  = 8'h04;
  localparam logic [7:0]  BYTE_COUNT    = 8'd20;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] line_voltage;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] line_frequency;
    logic [15:0] power_factor_raw;
    logic        alarm;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/mbrc_crc.sv
// Bytewise CRC-16/Modbus update (reflected, polynomial 0xA001).
// Depends on mbrc_pkg.
`default_nettype none

module mbrc_crc
  import mbrc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> rtl/mbrc_frame.sv
// Frame tracker: header checks, payload buffer, CRC state and counters.
// Depends on mbrc_pkg and mbrc_crc.
`default_nettype none

module mbrc_frame
  import mbrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_item_t  item,
  input  wire logic [7:0] device_address,
  output logic           res_fire,
  output out_item_t      res
);

  logic [15:0] running_crc;
  logic [4:0]  byte_index;
  logic        frame_open;
  logic [1:0]  header_flags;
  logic [7:0]  received_crc_low;
  logic [31:0] success_counter;
  logic [31:0] failure_counter;
  logic [7:0]  payload_store [PAYLOAD_BYTES];

  // Registered read of the payload buffer
  logic [15:0] voltage_word;
  logic [31:0] current_pair;
  logic [31:0] power_pair;
  logic [31:0] energy_pair;
  logic [15:0] frequency_word;
  logic [15:0] power_factor_word;
  logic        alarm_seen;

  logic [15:0] crc_upd;
  logic [4:0]  payload_addr;
  logic        is_byte;
  logic        is_timeout;
  logic        last_byte;
  logic [2:0]  status;
  logic        ok;

  mbrc_crc u_crc (
    .crc_in  (running_crc),
    .data    (item.rx_byte),
    .crc_out (crc_upd)
  );

  assign is_byte      = accept && frame_open && (item.command == CMD_BYTE);
  assign is_timeout   = accept && frame_open && (item.command == CMD_TIMEOUT);
  assign last_byte    = is_byte && (byte_index == IDX_CRC_HIGH);
  assign res_fire     = is_timeout || last_byte;
  assign payload_addr = byte_index - IDX_PAYLOAD;

  always_comb begin
    if (is_timeout) begin
      status = STAT_LENGTH;
    end else if (header_flags[0]) begin
      status = STAT_ADDRESS;
    end else if (header_flags[1]) begin
      status = STAT_FUNCTION;
    end else if ({item.rx_byte, received_crc_low} != running_crc) begin
      status = STAT_CRC;
    end else begin
      status = STAT_OK;
    end
  end

  assign ok = (status == STAT_OK);

  function automatic logic [15:0] word_at(input logic [7:0] hi, input logic [7:0] lo);
    return {hi, lo};
  endfunction

  always_comb begin
    res = '0;
    res.status = status;
    if (ok) begin
      res.line_voltage     = voltage_word;
      res.current_raw      = current_pair;
      res.power_raw        = power_pair;
      res.energy_raw       = energy_pair;
      res.line_frequency   = frequency_word;
      res.power_factor_raw = power_factor_word;
      res.alarm            = alarm_seen;
      res.good_frames      = success_counter + 32'd1;
      res.bad_frames       = failure_counter;
    end else begin
      res.good_frames      = success_counter;
      res.bad_frames       = failure_counter + 32'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc      <= CRC_SEED;
      byte_index       <= '0;
      frame_open       <= 1'b0;
      header_flags     <= '0;
      received_crc_low <= '0;
      success_counter  <= '0;
      failure_counter  <= '0;
    end else if (accept) begin
      if (item.command == CMD_START) begin
        running_crc  <= CRC_SEED;
        byte_index   <= '0;
        header_flags <= '0;
        frame_open   <= 1'b1;
      end else if (res_fire) begin
        frame_open <= 1'b0;
        if (ok) begin
          success_counter <= success_counter + 32'd1;
        end else begin
          failure_counter <= failure_counter + 32'd1;
        end
      end else if (is_byte) begin
        if (byte_index < IDX_CRC_LOW) begin
          running_crc <= crc_upd;
        end
        if (byte_index == IDX_ADDRESS && item.rx_byte != device_address) begin
          header_flags[0] <= 1'b1;
        end
        if (byte_index == IDX_FUNCTION && item.rx_byte != FUNC_READ_IN) begin
          header_flags[1] <= 1'b1;
        end
        if (byte_index == IDX_COUNT && item.rx_byte != BYTE_COUNT) begin
          header_flags[1] <= 1'b1;
        end
        if (byte_index == IDX_CRC_LOW) begin
          received_crc_low <= item.rx_byte;
        end
        byte_index <= byte_index + 5'd1;
      end
    end
  end

  // Payload buffer, one byte written per transaction; read out once the
  // low CRC byte arrives, when all payload bytes of the frame are in
  always_ff @(posedge clk) begin
    if (is_byte && byte_index >= IDX_PAYLOAD && byte_index < IDX_CRC_LOW) begin
      payload_store[payload_addr[PAYLOAD_AW-1:0]] <= item.rx_byte;
    end
    if (is_byte && byte_index == IDX_CRC_LOW) begin
      voltage_word      <= word_at(payload_store[0], payload_store[1]);
      current_pair      <= {word_at(payload_store[4], payload_store[5]),
                            word_at(payload_store[2], payload_store[3])};
      power_pair        <= {word_at(payload_store[8], payload_store[9]),
                            word_at(payload_store[6], payload_store[7])};
      energy_pair       <= {word_at(payload_store[12], payload_store[13]),
                            word_at(payload_store[10], payload_store[11])};
      frequency_word    <= word_at(payload_store[14], payload_store[15]);
      power_factor_word <= word_at(payload_store[16], payload_store[17]);
      alarm_seen        <= (word_at(payload_store[18], payload_store[19]) != 16'h0000);
    end
  end

endmodule

`default_nettype wire

>>> rtl/modbus_meter_response_checker.sv
// Top level of the Modbus RTU meter response checker.
// Depends on mbrc_pkg, mbrc_crc and mbrc_frame.
`default_nettype none

// Checks a 25-byte Modbus RTU reply to a read of ten input registers, fed
// one transaction per byte. Command 0 opens a frame (an open frame is
// dropped silently), command 1 delivers a byte, command 2 reports a
// response timeout. The CRC-16/Modbus runs over bytes 0..22 and is compared
// with the little-endian CRC in bytes 23/24; address, function 0x04 and
// byte count 20 are checked too. On the 25th byte or on a timeout with a
// frame open, one result transaction carries the status, the decoded
// measurements (zero unless status is ok) and the wrapping good/bad
// counters. For each accepted input transaction the byte CRC update,
// header check and payload write all finish in the accept cycle, and the
// result lands in a one-deep output register. Input is accepted whenever
// that register is empty or being drained, so with a continuously ready consumer
// input flows at one byte per clock. device_address is written through the cfg
// channel (always ready) and resets to 1; write it only while idle.
module modbus_meter_response_checker
  import mbrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic       accept;
  logic       res_fire;
  out_item_t  res;
  logic [7:0] device_address;

  assign cfg_ready = 1'b1;
  // Output register frees up in the same cycle it is drained
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg_valid) begin
      device_address <= cfg_data;
    end
  end

  mbrc_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (in_data),
    .device_address (device_address),
    .res_fire       (res_fire),
    .res            (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

>>> tb/modbus_meter_response_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modbus_meter_response_checker: byte streams of
// Modbus RTU replies are checked against a local frame decoder and counters.
// Depends on mbrc_pkg and the rtl of the checker; needs no other file.

module modbus_meter_response_checker_tb
  import mbrc_pkg::*;
();

  localparam int         CLK_HALF      = 4;
  localparam int         RESET_CYCLES  = 11;
  localparam int         CYCLE_LIMIT   = 100000;
  localparam int         SETTLE_CYCLES = 4;     // result register plus margin
  localparam int         TAIL_CYCLES   = 10;
  localparam int         FRAME_BYTES   = 25;
  localparam int         MAX_REPORTS   = 10;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;  // no meaning, must be ignored

  // Receiver stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_FOURTH,
    RDY_SPARSE
  } stall_mode_e;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'd0;

  always #CLK_HALF clk = ~clk;

  modbus_meter_response_checker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Frame decoder: mirrors the checker state, updated once per accepted
  // input transaction, and queues the reading each closed frame produces.
  // ---------------------------------------------------------------------------
  logic [7:0]  exp_dev_addr;
  logic [15:0] crc_acc;
  logic [4:0]  frame_pos;
  logic        frame_live;
  logic [1:0]  hdr_bad;        // bit0 address, bit1 function or byte count
  logic [7:0]  reg_bytes [PAYLOAD_BYTES];
  logic [7:0]  crc_low_seen;
  logic [31:0] good_count;
  logic [31:0] bad_count;
  out_item_t   expected_readings [$];

  int items_sent       = 0;
  int replies_expected = 0;
  int replies_checked  = 0;
  int mismatch_count   = 0;
  int addr_writes      = 0;

  // Reflected CRC-16, polynomial 0xA001, one byte
  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Big-endian register from the payload
  function automatic logic [15:0] reg16(input int i);
    return {reg_bytes[i], reg_bytes[i + 1]};
  endfunction

  // 32-bit quantity, low word first
  function automatic logic [31:0] pair32(input int i);
    return {reg16(i + 2), reg16(i)};
  endfunction

  task automatic close_frame(input logic [2:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    if (st == STAT_OK) begin
      good_count          = good_count + 32'd1;
      r.line_voltage      = reg16(0);
      r.current_raw       = pair32(2);
      r.power_raw         = pair32(6);
      r.energy_raw        = pair32(10);
      r.line_frequency    = reg16(14);
      r.power_factor_raw  = reg16(16);
      r.alarm             = (reg16(18) != 16'd0);
    end else begin
      // rejected frames report only status and counters
      bad_count = bad_count + 32'd1;
    end
    r.good_frames = good_count;
    r.bad_frames  = bad_count;
    expected_readings.push_back(r);
    replies_expected++;
    frame_live = 1'b0;
  endtask

  task automatic predict_meter_item(input in_item_t it);
    logic [2:0] st;
    case (it.command)
      CMD_START: begin
        // an open frame is dropped without a reading
        crc_acc    = CRC_SEED;
        frame_pos  = IDX_ADDRESS;
        hdr_bad    = 2'b00;
        frame_live = 1'b1;
      end
      CMD_TIMEOUT: begin
        if (frame_live)
          close_frame(STAT_LENGTH);
      end
      CMD_BYTE: begin
        if (frame_live) begin
          if (frame_pos < IDX_CRC_LOW)
            crc_acc = crc16_modbus(crc_acc, it.rx_byte);
          if (frame_pos == IDX_ADDRESS) begin
            if (it.rx_byte != exp_dev_addr)
              hdr_bad[0] = 1'b1;
          end else if (frame_pos == IDX_FUNCTION) begin
            if (it.rx_byte != FUNC_READ_IN)
              hdr_bad[1] = 1'b1;
          end else if (frame_pos == IDX_COUNT) begin
            if (it.rx_byte != BYTE_COUNT)
              hdr_bad[1] = 1'b1;
          end else if (frame_pos < IDX_CRC_LOW) begin
            reg_bytes[frame_pos - IDX_PAYLOAD] = it.rx_byte;
          end else if (frame_pos == IDX_CRC_LOW) begin
            crc_low_seen = it.rx_byte;
          end else begin
            // last byte: address beats function/count beats crc
            if (hdr_bad[0])
              st = STAT_ADDRESS;
            else if (hdr_bad[1])
              st = STAT_FUNCTION;
            else if ({it.rx_byte, crc_low_seen} != crc_acc)
              st = STAT_CRC;
            else
              st = STAT_OK;
            close_frame(st);
          end
          if (frame_live)
            frame_pos = frame_pos + 5'd1;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length separated by random gaps while gaps_on is set.
  // Every task here starts and returns at a falling edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  task automatic idle_input(input int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    in_item_t it;
    it.command = cmd;
    it.rx_byte = b;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      idle_input($urandom_range(1, 9));
    end
    if (burst_left > 0)
      burst_left--;
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predict_meter_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every queued reading has been seen, then lets the block settle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_device_address(input logic [7:0] a);
    wait_drained();
    cfg_data  = a;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    exp_dev_addr = a;
    addr_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Frame assembly
  // ---------------------------------------------------------------------------
  logic [7:0] frame_buf [FRAME_BYTES];

  task automatic seal_frame();
    logic [15:0] c;
    c = CRC_SEED;
    for (int i = 0; i < IDX_CRC_LOW; i++)
      c = crc16_modbus(c, frame_buf[i]);
    frame_buf[IDX_CRC_LOW]  = c[7:0];
    frame_buf[IDX_CRC_HIGH] = c[15:8];
  endtask

  // Well-formed reply with random registers; alarm register often zero
  task automatic build_frame(input logic [7:0] addr);
    frame_buf[IDX_ADDRESS]  = addr;
    frame_buf[IDX_FUNCTION] = FUNC_READ_IN;
    frame_buf[IDX_COUNT]    = BYTE_COUNT;
    for (int i = IDX_PAYLOAD; i < IDX_CRC_LOW; i++)
      frame_buf[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) begin
      frame_buf[IDX_CRC_LOW - 2] = 8'h00;
      frame_buf[IDX_CRC_LOW - 1] = 8'h00;
    end
    seal_frame();
  endtask

  task automatic fill_payload(input logic [7:0] v);
    for (int i = IDX_PAYLOAD; i < IDX_CRC_LOW; i++)
      frame_buf[i] = v;
    seal_frame();
  endtask

  // Sends frame_buf[first .. last-1] as byte transactions
  task automatic send_bytes(input int first, input int last);
    for (int i = first; i < last; i++)
      send_item(CMD_BYTE, frame_buf[i]);
  endtask

  task automatic send_frame();
    send_item(CMD_START, 8'($urandom_range(0, 255)));
    send_bytes(0, FRAME_BYTES);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Good replies at the reset address, registers at both extremes
  task automatic test_reset_address_frames();
    build_frame(exp_dev_addr);
    fill_payload(8'h00);
    send_frame();
    fill_payload(8'hFF);
    send_frame();
    build_frame(exp_dev_addr);
    send_frame();
  endtask

  // Each header check, crc faults, and the status priority
  task automatic test_header_errors();
    build_frame(exp_dev_addr ^ 8'h80);
    send_frame();
    build_frame(exp_dev_addr);
    frame_buf[IDX_FUNCTION] = 8'h03;
    seal_frame();
    send_frame();
    build_frame(exp_dev_addr);
    frame_buf[IDX_COUNT] = BYTE_COUNT - 8'd1;
    seal_frame();
    send_frame();
    // address and function both wrong: address wins
    build_frame(exp_dev_addr ^ 8'h01);
    frame_buf[IDX_FUNCTION] = 8'hFF;
    seal_frame();
    send_frame();
    // function wrong and crc wrong: function wins
    build_frame(exp_dev_addr);
    frame_buf[IDX_FUNCTION] = 8'h00;
    send_frame();
    build_frame(exp_dev_addr);
    frame_buf[IDX_CRC_HIGH] ^= 8'h80;
    send_frame();
    build_frame(exp_dev_addr);
    frame_buf[IDX_CRC_LOW] ^= 8'h01;
    send_frame();
    build_frame(exp_dev_addr);
    frame_buf[IDX_PAYLOAD + 7] ^= 8'h10;
    send_frame();
  endtask

  // Commands outside a frame, timeouts, restarts and stray bytes
  task automatic test_framing_cases();
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_UNUSED, 8'hFF);
    // timeout before any byte
    send_item(CMD_START, 8'hFF);
    send_item(CMD_TIMEOUT, 8'hFF);
    build_frame(exp_dev_addr);
    send_item(CMD_START, 8'h00);
    send_bytes(0, 10);
    send_item(CMD_TIMEOUT, 8'h00);
    // timeout one byte short of a full frame
    send_item(CMD_START, 8'h00);
    send_bytes(0, FRAME_BYTES - 1);
    send_item(CMD_TIMEOUT, 8'h55);
    // restart drops the partial frame silently
    send_item(CMD_START, 8'h00);
    send_bytes(0, 12);
    send_frame();
    // unused command inside a frame changes nothing
    build_frame(exp_dev_addr);
    send_item(CMD_START, 8'hAA);
    send_bytes(0, 5);
    send_item(CMD_UNUSED, 8'h00);
    send_bytes(5, FRAME_BYTES);
    // after the frame closes, bytes and timeout are ignored
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TIMEOUT, 8'hFF);
  endtask

  // Address register at its extremes
  task automatic test_address_setting();
    write_device_address(8'h00);
    build_frame(8'h00);
    send_frame();
    build_frame(8'h01);
    send_frame();
    write_device_address(8'hFF);
    build_frame(8'hFF);
    send_frame();
    build_frame(8'h00);
    send_frame();
  endtask

  // Mostly well-formed replies with random content, the rest corrupted,
  // truncated or noise. Closes any open frame at the end.
  task automatic test_random_traffic(input int min_items, input int min_replies);
    int first_item;
    int first_reply;
    int kind;
    int cut;
    int pos;
    first_item  = items_sent;
    first_reply = replies_expected;
    while (items_sent - first_item < min_items ||
           replies_expected - first_reply < min_replies) begin
      kind = $urandom_range(0, 99);
      build_frame(exp_dev_addr);
      if (kind < 60) begin
        send_frame();
      end else if (kind < 68) begin
        pos = $urandom_range(IDX_PAYLOAD, IDX_CRC_HIGH);
        frame_buf[pos] ^= 8'($urandom_range(1, 255));
        send_frame();
      end else if (kind < 74) begin
        pos = $urandom_range(IDX_ADDRESS, IDX_COUNT);
        frame_buf[pos] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1))
          seal_frame();
        send_frame();
      end else if (kind < 82) begin
        cut = $urandom_range(0, FRAME_BYTES - 1);
        send_item(CMD_START, 8'($urandom_range(0, 255)));
        send_bytes(0, cut);
        send_item(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
        // partial frame left open for whatever comes next
        cut = $urandom_range(1, FRAME_BYTES - 1);
        send_item(CMD_START, 8'($urandom_range(0, 255)));
        send_bytes(0, cut);
      end else begin
        repeat ($urandom_range(1, 5))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    send_item(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready follows a stall pattern that is picked anew at random
  // ---------------------------------------------------------------------------
  stall_mode_e ready_mode  = RDY_ALWAYS;
  int          mode_cycles = 0;

  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode  = stall_mode_e'($urandom_range(0, 3));
      mode_cycles = $urandom_range(20, 120);
    end
    mode_cycles--;
    case (ready_mode)
      RDY_ALWAYS:       out_ready <= 1'b1;
      RDY_COIN:         out_ready <= 1'($urandom_range(0, 1));
      RDY_EVERY_FOURTH: out_ready <= (mode_cycles % 4 == 0);
      default:          out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Reading check: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_readings
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      replies_checked++;
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result transaction, status %0d", $realtime,
                   out_data.status);
      end else begin
        want = expected_readings.pop_front();
        check_field("status",           want.status,           out_data.status);
        check_field("line_voltage",     want.line_voltage,     out_data.line_voltage);
        check_field("current_raw",      want.current_raw,      out_data.current_raw);
        check_field("power_raw",        want.power_raw,        out_data.power_raw);
        check_field("energy_raw",       want.energy_raw,       out_data.energy_raw);
        check_field("line_frequency",   want.line_frequency,   out_data.line_frequency);
        check_field("power_factor_raw", want.power_factor_raw, out_data.power_factor_raw);
        check_field("alarm",            want.alarm,            out_data.alarm);
        check_field("good_frames",      want.good_frames,      out_data.good_frames);
        check_field("bad_frames",       want.bad_frames,       out_data.bad_frames);
      end
    end
  end

  // Watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings outstanding", cycle_count,
               expected_readings.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    exp_dev_addr = 8'd1;
    crc_acc      = CRC_SEED;
    frame_pos    = 5'd0;
    frame_live   = 1'b0;
    hdr_bad      = 2'b00;
    crc_low_seen = 8'd0;
    good_count   = 32'd0;
    bad_count    = 32'd0;
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      reg_bytes[i] = 8'd0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_address_frames();
    test_header_errors();
    test_framing_cases();
    test_address_setting();
    // random traffic under several addresses; one phase without input gaps
    for (int p = 0; p < 4; p++) begin
      write_device_address(p == 0 ? 8'd1 : 8'($urandom_range(0, 255)));
      gaps_on = (p != 2);
      test_random_traffic(70, 2);
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d input transactions, checked %0d readings (%0d good, %0d rejected)",
             items_sent, replies_checked, good_count, bad_count);
    $display("Device address written %0d times; %0d mismatches", addr_writes,
             mismatch_count);
    if (mismatch_count == 0 && expected_readings.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
